/* hw/rtl/taje_pkg.sv */
// Shared constants, types and helpers for the tree ancestor jump engine.
// No dependencies; every other file but taje_ram refers to it by scoped names.
package taje_pkg;

    localparam int NODE_W     = 10;
    localparam int MAX_NODES  = 1 << NODE_W;
    localparam int ID_W       = NODE_W + 1;         // node id plus room for the none marker
    localparam int DEPTH_W    = 11;
    localparam int SPAN_W     = DEPTH_W + 1;        // depth difference with a borrow bit
    localparam int DIST_W     = 10;
    localparam int OP_W       = 2;
    localparam int STEP_LIMIT = 4 * MAX_NODES;
    localparam int BUDGET_W   = $clog2(STEP_LIMIT + 1);
    localparam int ENTRY_W    = 2 * ID_W + DEPTH_W;

    localparam logic [ID_W-1:0]    NONE_ID   = '1;
    localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ROOT   = 2'd0,
        OP_ATTACH = 2'd1,
        OP_KTH    = 2'd2,
        OP_LCA    = 2'd3
    } t_op;

    typedef struct packed {
        logic [ID_W-1:0]    par;
        logic [DEPTH_W-1:0] dep;
        logic [ID_W-1:0]    jmp;
    } t_entry;

    typedef enum logic [2:0] {
        ADDR_U, ADDR_V, ADDR_JU, ADDR_JV, ADDR_JJ
    } t_addr_sel;

    typedef enum logic [1:0] {
        LD_NONE, LD_U, LD_V, LD_J
    } t_ld_sel;

    typedef enum logic [2:0] {
        UPD_NONE, UPD_SWAP, UPD_CLIMB_J, UPD_CLIMB_P,
        UPD_L1_J, UPD_L1_P, UPD_L2_J, UPD_L2_P
    } t_upd;

    typedef enum logic [1:0] {
        RES_U, RES_PAR_U, RES_NONE
    } t_res_sel;

    typedef enum logic [1:0] {
        WR_ROOT, WR_PAR, WR_SKEW
    } t_wr_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WR_ROOT,
        S_A_RD, S_A_LD_P, S_A_CHK_P, S_A_LD_P2, S_A_CHK_P2, S_A_LD_P3,
        S_A_WR_PAR, S_A_WR_SKEW,
        S_K_TOP, S_K_LD_U, S_K_J, S_K_LD_J, S_K_DEC,
        S_L_RD, S_L_LD_U, S_L_LD_V, S_L_ORD,
        S_L1_TOP, S_L1_LD_J, S_L1_DEC, S_L1_CHK, S_L1_LD_U,
        S_L_EQ,
        S_L2_TOP, S_L2_CHK, S_L2_LD_U, S_L2_LD_V,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic      load_in;
        logic      rd_en;
        t_addr_sel addr_sel;
        t_ld_sel   ld_sel;
        t_upd      upd;
        logic      set_res;
        t_res_sel  res_sel;
        logic      emit;
        logic      wr_en;
        t_wr_sel   wr_sel;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic k_zero;
        logic u_ok;
        logic v_ok;
        logic ju_ok;
        logic jv_ok;
        logic jj_ok;
        logic climb_jump;
        logic du_lt_dv;
        logic dv_lt_du;
        logic l1_jump;
        logic u_eq_v;
        logic par_eq;
        logic l2_jump;
        logic budget_zero;
    } t_stat;

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return id < ID_W'(MAX_NODES);
    endfunction

endpackage

/* hw/rtl/taje_in_if.sv */
// Request channel of the tree ancestor jump engine: valid/ready plus item fields.
// Depends on taje_pkg for field widths.
interface taje_in_if;
    logic                         valid;
    logic                         ready;
    logic [taje_pkg::OP_W-1:0]    op;
    logic [taje_pkg::NODE_W-1:0]  node_a;
    logic [taje_pkg::NODE_W-1:0]  node_b;
    logic [taje_pkg::DIST_W-1:0]  distance;

    modport source (output valid, op, node_a, node_b, distance, input ready);
    modport sink   (input valid, op, node_a, node_b, distance, output ready);
endinterface

/* hw/rtl/taje_out_if.sv */
// Answer channel of the tree ancestor jump engine: valid/ready plus answer fields.
// Depends on taje_pkg for field widths.
interface taje_out_if;
    logic                         valid;
    logic                         ready;
    logic [taje_pkg::NODE_W-1:0]  answer_node;
    logic                         answer_found;

    modport source (output valid, answer_node, answer_found, input ready);
    modport sink   (input valid, answer_node, answer_found, output ready);
endinterface

/* hw/rtl/tree_ancestor_jump_engine.sv */
// Top level of the tree ancestor jump engine: controller plus datapath.
// Depends on taje_pkg, taje_in_if, taje_out_if, taje_ctrl, taje_dp (and taje_ram).
//
//  channel  dir  handshake      fields
//  i_req    in   valid/ready    op, node_a, node_b, distance
//  o_rsp    out  valid/ready    answer_node, answer_found
//
// One request at a time; every table read is a registered read of one RAM port.
// Root writes a root entry. Attach reads the parent, then its jump and jump-of-jump when valid.
// K-th ancestor climbs by jump links where they do not overshoot, else by parent links.
// Common ancestor climbs the deeper node to the other's depth, then steps both in pairs.
// Synchronous active-low reset clears the sequencer and the answer valid; the node
// table is not cleared. A held answer does not block the next request; only a
// second answer waits until the first is taken.
module tree_ancestor_jump_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    taje_in_if.sink    i_req,
    taje_out_if.source o_rsp
);
    taje_pkg::t_cmd  w_cmd;
    taje_pkg::t_stat w_stat;

    taje_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .i_in_op   (i_req.op),
        .i_stat    (w_stat),
        .o_in_ready(i_req.ready),
        .o_cmd     (w_cmd)
    );

    taje_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_node_a      (i_req.node_a),
        .i_node_b      (i_req.node_b),
        .i_distance    (i_req.distance),
        .i_out_ready   (o_rsp.ready),
        .o_stat        (w_stat),
        .o_out_valid   (o_rsp.valid),
        .o_answer_node (o_rsp.answer_node),
        .o_answer_found(o_rsp.answer_found)
    );

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_stat.out_free)
        else $error("answer loaded while previous answer still held");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_rsp.valid)
        else $error("loaded answer not presented");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous one in progress");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_rsp.valid && i_req.ready))
        else $error("reset did not return to idle");
endmodule

/* hw/rtl/taje_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module taje_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/taje_dp.sv */
// Datapath: node table RAM, walk registers, step arithmetic and answer register.
// Depends on taje_pkg and taje_ram; driven by taje_ctrl through t_cmd / t_stat.
module taje_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  taje_pkg::t_cmd               i_cmd,
    input  logic [taje_pkg::NODE_W-1:0]  i_node_a,
    input  logic [taje_pkg::NODE_W-1:0]  i_node_b,
    input  logic [taje_pkg::DIST_W-1:0]  i_distance,
    input  logic                         i_out_ready,
    output taje_pkg::t_stat              o_stat,
    output logic                         o_out_valid,
    output logic [taje_pkg::NODE_W-1:0]  o_answer_node,
    output logic                         o_answer_found
);
    logic [taje_pkg::ID_W-1:0]     r_u, n_u, r_v, n_v, r_res, n_res;
    logic [taje_pkg::DIST_W-1:0]   r_k, n_k;
    logic [taje_pkg::BUDGET_W-1:0] r_budget, n_budget;
    taje_pkg::t_entry              r_eu, n_eu, r_ev, n_ev, r_ej, n_ej;
    logic                          r_out_valid;
    logic [taje_pkg::NODE_W-1:0]   r_out_node;
    logic                          r_out_found;

    logic [taje_pkg::NODE_W-1:0]   w_raddr;
    logic [taje_pkg::ENTRY_W-1:0]  w_rdata;
    taje_pkg::t_entry              w_rd_entry, w_wr_entry;
    logic [taje_pkg::DEPTH_W-1:0]  w_dep_diff, w_child_dep;
    logic [taje_pkg::SPAN_W-1:0]   w_span_hi, w_span_lo;
    logic                          w_skew_eq, w_ju_ok, w_jv_ok, w_res_ok;

    taje_ram #(
        .WIDTH(taje_pkg::ENTRY_W),
        .DEPTH(taje_pkg::MAX_NODES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_en),
        .i_waddr(r_u[taje_pkg::NODE_W-1:0]),
        .i_wdata(w_wr_entry),
        .i_re   (i_cmd.rd_en),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd_entry = taje_pkg::t_entry'(w_rdata);

    always_comb begin
        unique case (i_cmd.addr_sel)
            taje_pkg::ADDR_U:  w_raddr = r_u[taje_pkg::NODE_W-1:0];
            taje_pkg::ADDR_V:  w_raddr = r_v[taje_pkg::NODE_W-1:0];
            taje_pkg::ADDR_JU: w_raddr = r_eu.jmp[taje_pkg::NODE_W-1:0];
            taje_pkg::ADDR_JV: w_raddr = r_ev.jmp[taje_pkg::NODE_W-1:0];
            taje_pkg::ADDR_JJ: w_raddr = r_ej.jmp[taje_pkg::NODE_W-1:0];
            default:           w_raddr = r_u[taje_pkg::NODE_W-1:0];
        endcase
    end

    // attach: parent in ev, its jump in ej, jump-of-jump in eu
    assign w_span_hi   = {1'b0, r_ev.dep} - {1'b0, r_ej.dep};
    assign w_span_lo   = {1'b0, r_ej.dep} - {1'b0, r_eu.dep};
    assign w_skew_eq   = (w_span_hi == w_span_lo);
    assign w_child_dep = (r_ev.dep == taje_pkg::DEPTH_SAT) ? taje_pkg::DEPTH_SAT
                                                            : r_ev.dep + 1'b1;

    always_comb begin
        unique case (i_cmd.wr_sel)
            taje_pkg::WR_ROOT: begin
                w_wr_entry.par = taje_pkg::NONE_ID;
                w_wr_entry.dep = taje_pkg::DEPTH_W'(1);
                w_wr_entry.jmp = taje_pkg::NONE_ID;
            end
            taje_pkg::WR_SKEW: begin
                w_wr_entry.par = r_v;
                w_wr_entry.dep = w_child_dep;
                w_wr_entry.jmp = w_skew_eq ? r_ej.jmp : r_v;
            end
            default: begin
                w_wr_entry.par = r_v;
                w_wr_entry.dep = w_child_dep;
                w_wr_entry.jmp = r_v;
            end
        endcase
    end

    assign w_dep_diff = r_eu.dep - r_ej.dep;
    assign w_ju_ok    = taje_pkg::id_ok(r_eu.jmp);
    assign w_jv_ok    = taje_pkg::id_ok(r_ev.jmp);

    always_comb begin
        o_stat.out_free    = !r_out_valid || i_out_ready;
        o_stat.k_zero      = (r_k == '0);
        o_stat.u_ok        = taje_pkg::id_ok(r_u);
        o_stat.v_ok        = taje_pkg::id_ok(r_v);
        o_stat.ju_ok       = w_ju_ok;
        o_stat.jv_ok       = w_jv_ok;
        o_stat.jj_ok       = taje_pkg::id_ok(r_ej.jmp);
        o_stat.climb_jump  = w_ju_ok && (r_ej.dep < r_eu.dep) &&
                             (w_dep_diff <= taje_pkg::DEPTH_W'(r_k));
        o_stat.du_lt_dv    = (r_eu.dep < r_ev.dep);
        o_stat.dv_lt_du    = (r_ev.dep < r_eu.dep);
        o_stat.l1_jump     = w_ju_ok && (r_ev.dep <= r_ej.dep);
        o_stat.u_eq_v      = (r_u == r_v);
        o_stat.par_eq      = (r_eu.par == r_ev.par);
        o_stat.l2_jump     = w_ju_ok && w_jv_ok && (r_eu.jmp != r_ev.jmp);
        o_stat.budget_zero = (r_budget == '0);
    end

    always_comb begin
        n_u      = r_u;
        n_v      = r_v;
        n_k      = r_k;
        n_budget = r_budget;
        n_eu     = r_eu;
        n_ev     = r_ev;
        n_ej     = r_ej;
        n_res    = r_res;

        if (i_cmd.load_in) begin
            n_u      = {1'b0, i_node_a};
            n_v      = {1'b0, i_node_b};
            n_k      = i_distance;
            n_budget = taje_pkg::BUDGET_W'(taje_pkg::STEP_LIMIT);
        end

        unique case (i_cmd.ld_sel)
            taje_pkg::LD_NONE: ;
            taje_pkg::LD_U:    n_eu = w_rd_entry;
            taje_pkg::LD_V:    n_ev = w_rd_entry;
            taje_pkg::LD_J:    n_ej = w_rd_entry;
        endcase

        unique case (i_cmd.upd)
            taje_pkg::UPD_NONE: ;
            taje_pkg::UPD_SWAP: begin
                n_u  = r_v;
                n_v  = r_u;
                n_eu = r_ev;
                n_ev = r_eu;
            end
            taje_pkg::UPD_CLIMB_J: begin
                n_k  = r_k - w_dep_diff[taje_pkg::DIST_W-1:0];
                n_u  = r_eu.jmp;
                n_eu = r_ej;
            end
            taje_pkg::UPD_CLIMB_P: begin
                n_k = r_k - 1'b1;
                n_u = r_eu.par;
            end
            taje_pkg::UPD_L1_J: begin
                n_budget = r_budget - 1'b1;
                n_u      = r_eu.jmp;
                n_eu     = r_ej;
            end
            taje_pkg::UPD_L1_P: begin
                n_budget = r_budget - 1'b1;
                n_u      = r_eu.par;
            end
            taje_pkg::UPD_L2_J: begin
                n_budget = r_budget - 1'b1;
                n_u      = r_eu.jmp;
                n_v      = r_ev.jmp;
            end
            taje_pkg::UPD_L2_P: begin
                n_budget = r_budget - 1'b1;
                n_u      = r_eu.par;
                n_v      = r_ev.par;
            end
        endcase

        if (i_cmd.set_res) begin
            unique case (i_cmd.res_sel)
                taje_pkg::RES_U:     n_res = r_u;
                taje_pkg::RES_PAR_U: n_res = r_eu.par;
                default:             n_res = taje_pkg::NONE_ID;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_u      <= n_u;
        r_v      <= n_v;
        r_k      <= n_k;
        r_budget <= n_budget;
        r_eu     <= n_eu;
        r_ev     <= n_ev;
        r_ej     <= n_ej;
        r_res    <= n_res;
    end

    assign w_res_ok = taje_pkg::id_ok(r_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_node  <= w_res_ok ? r_res[taje_pkg::NODE_W-1:0] : '0;
            r_out_found <= w_res_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_answer_node  = r_out_node;
    assign o_answer_found = r_out_found;
endmodule

/* hw/rtl/taje_ctrl.sv */
// Controller: sequences table reads and writes for root, attach and both queries.
// Depends on taje_pkg; talks to taje_dp only through t_cmd / t_stat.
module taje_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [taje_pkg::OP_W-1:0] i_in_op,
    input  taje_pkg::t_stat           i_stat,
    output logic                      o_in_ready,
    output taje_pkg::t_cmd            o_cmd
);
    taje_pkg::t_state r_state, n_state;
    taje_pkg::t_op    w_op;

    assign w_op = taje_pkg::t_op'(i_in_op);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= taje_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            taje_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (w_op)
                        taje_pkg::OP_ROOT:   n_state = taje_pkg::S_WR_ROOT;
                        taje_pkg::OP_ATTACH: n_state = taje_pkg::S_A_RD;
                        taje_pkg::OP_KTH:    n_state = taje_pkg::S_K_TOP;
                        taje_pkg::OP_LCA:    n_state = taje_pkg::S_L_RD;
                    endcase
                end
            end
            taje_pkg::S_WR_ROOT:   n_state = taje_pkg::S_IDLE;
            taje_pkg::S_A_RD:      n_state = taje_pkg::S_A_LD_P;
            taje_pkg::S_A_LD_P:    n_state = taje_pkg::S_A_CHK_P;
            taje_pkg::S_A_CHK_P:   n_state = i_stat.jv_ok ? taje_pkg::S_A_LD_P2
                                                          : taje_pkg::S_A_WR_PAR;
            taje_pkg::S_A_LD_P2:   n_state = taje_pkg::S_A_CHK_P2;
            taje_pkg::S_A_CHK_P2:  n_state = i_stat.jj_ok ? taje_pkg::S_A_LD_P3
                                                          : taje_pkg::S_A_WR_PAR;
            taje_pkg::S_A_LD_P3:   n_state = taje_pkg::S_A_WR_SKEW;
            taje_pkg::S_A_WR_PAR,
            taje_pkg::S_A_WR_SKEW: n_state = taje_pkg::S_IDLE;
            taje_pkg::S_K_TOP: begin
                n_state = (i_stat.k_zero || !i_stat.u_ok) ? taje_pkg::S_EMIT
                                                           : taje_pkg::S_K_LD_U;
            end
            taje_pkg::S_K_LD_U:    n_state = taje_pkg::S_K_J;
            taje_pkg::S_K_J: begin
                priority if (i_stat.k_zero) begin
                    n_state = taje_pkg::S_EMIT;
                end else if (i_stat.ju_ok) begin
                    n_state = taje_pkg::S_K_LD_J;
                end else begin
                    n_state = taje_pkg::S_K_TOP;
                end
            end
            taje_pkg::S_K_LD_J:    n_state = taje_pkg::S_K_DEC;
            taje_pkg::S_K_DEC: begin
                n_state = i_stat.climb_jump ? taje_pkg::S_K_J : taje_pkg::S_K_TOP;
            end
            taje_pkg::S_L_RD:      n_state = taje_pkg::S_L_LD_U;
            taje_pkg::S_L_LD_U:    n_state = taje_pkg::S_L_LD_V;
            taje_pkg::S_L_LD_V:    n_state = taje_pkg::S_L_ORD;
            taje_pkg::S_L_ORD:     n_state = taje_pkg::S_L1_TOP;
            taje_pkg::S_L1_TOP: begin
                priority if (!i_stat.dv_lt_du) begin
                    n_state = taje_pkg::S_L_EQ;
                end else if (i_stat.budget_zero) begin
                    n_state = taje_pkg::S_EMIT;
                end else if (i_stat.ju_ok) begin
                    n_state = taje_pkg::S_L1_LD_J;
                end else begin
                    n_state = taje_pkg::S_L1_CHK;
                end
            end
            taje_pkg::S_L1_LD_J:   n_state = taje_pkg::S_L1_DEC;
            taje_pkg::S_L1_DEC: begin
                n_state = i_stat.l1_jump ? taje_pkg::S_L1_TOP : taje_pkg::S_L1_CHK;
            end
            taje_pkg::S_L1_CHK: begin
                n_state = i_stat.u_ok ? taje_pkg::S_L1_LD_U : taje_pkg::S_EMIT;
            end
            taje_pkg::S_L1_LD_U:   n_state = taje_pkg::S_L1_TOP;
            taje_pkg::S_L_EQ: begin
                n_state = i_stat.u_eq_v ? taje_pkg::S_EMIT : taje_pkg::S_L2_TOP;
            end
            taje_pkg::S_L2_TOP: begin
                n_state = (i_stat.par_eq || i_stat.budget_zero) ? taje_pkg::S_EMIT
                                                                 : taje_pkg::S_L2_CHK;
            end
            taje_pkg::S_L2_CHK: begin
                n_state = (i_stat.u_ok && i_stat.v_ok) ? taje_pkg::S_L2_LD_U
                                                       : taje_pkg::S_EMIT;
            end
            taje_pkg::S_L2_LD_U:   n_state = taje_pkg::S_L2_LD_V;
            taje_pkg::S_L2_LD_V:   n_state = taje_pkg::S_L2_TOP;
            taje_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = taje_pkg::S_IDLE;
                end
            end
            default:               n_state = taje_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.load_in    = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.addr_sel   = taje_pkg::ADDR_U;
        o_cmd.ld_sel     = taje_pkg::LD_NONE;
        o_cmd.upd        = taje_pkg::UPD_NONE;
        o_cmd.set_res    = 1'b0;
        o_cmd.res_sel    = taje_pkg::RES_NONE;
        o_cmd.emit       = 1'b0;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wr_sel     = taje_pkg::WR_PAR;

        unique case (r_state)
            taje_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            taje_pkg::S_WR_ROOT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = taje_pkg::WR_ROOT;
            end
            taje_pkg::S_A_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = taje_pkg::ADDR_V;
            end
            taje_pkg::S_A_LD_P:  o_cmd.ld_sel = taje_pkg::LD_V;
            taje_pkg::S_A_CHK_P: begin
                o_cmd.rd_en    = i_stat.jv_ok;
                o_cmd.addr_sel = taje_pkg::ADDR_JV;
            end
            taje_pkg::S_A_LD_P2: o_cmd.ld_sel = taje_pkg::LD_J;
            taje_pkg::S_A_CHK_P2: begin
                o_cmd.rd_en    = i_stat.jj_ok;
                o_cmd.addr_sel = taje_pkg::ADDR_JJ;
            end
            taje_pkg::S_A_LD_P3: o_cmd.ld_sel = taje_pkg::LD_U;
            taje_pkg::S_A_WR_PAR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = taje_pkg::WR_PAR;
            end
            taje_pkg::S_A_WR_SKEW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = taje_pkg::WR_SKEW;
            end
            taje_pkg::S_K_TOP: begin
                if (i_stat.k_zero || !i_stat.u_ok) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = taje_pkg::RES_U;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = taje_pkg::ADDR_U;
                end
            end
            taje_pkg::S_K_LD_U: o_cmd.ld_sel = taje_pkg::LD_U;
            taje_pkg::S_K_J: begin
                priority if (i_stat.k_zero) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = taje_pkg::RES_U;
                end else if (i_stat.ju_ok) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = taje_pkg::ADDR_JU;
                end else begin
                    o_cmd.upd = taje_pkg::UPD_CLIMB_P;
                end
            end
            taje_pkg::S_K_LD_J: o_cmd.ld_sel = taje_pkg::LD_J;
            taje_pkg::S_K_DEC: begin
                o_cmd.upd = i_stat.climb_jump ? taje_pkg::UPD_CLIMB_J
                                              : taje_pkg::UPD_CLIMB_P;
            end
            taje_pkg::S_L_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = taje_pkg::ADDR_U;
            end
            taje_pkg::S_L_LD_U, taje_pkg::S_L2_LD_U: begin
                o_cmd.ld_sel   = taje_pkg::LD_U;
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = taje_pkg::ADDR_V;
            end
            taje_pkg::S_L_LD_V, taje_pkg::S_L2_LD_V: o_cmd.ld_sel = taje_pkg::LD_V;
            taje_pkg::S_L_ORD: begin
                if (i_stat.du_lt_dv) begin
                    o_cmd.upd = taje_pkg::UPD_SWAP;
                end
            end
            taje_pkg::S_L1_TOP: begin
                priority if (!i_stat.dv_lt_du) begin
                    o_cmd.upd = taje_pkg::UPD_NONE;
                end else if (i_stat.budget_zero) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = taje_pkg::RES_NONE;
                end else if (i_stat.ju_ok) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = taje_pkg::ADDR_JU;
                end else begin
                    o_cmd.upd = taje_pkg::UPD_L1_P;
                end
            end
            taje_pkg::S_L1_LD_J: o_cmd.ld_sel = taje_pkg::LD_J;
            taje_pkg::S_L1_DEC: begin
                o_cmd.upd = i_stat.l1_jump ? taje_pkg::UPD_L1_J : taje_pkg::UPD_L1_P;
            end
            taje_pkg::S_L1_CHK: begin
                if (i_stat.u_ok) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = taje_pkg::ADDR_U;
                end else begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = taje_pkg::RES_NONE;
                end
            end
            taje_pkg::S_L1_LD_U: o_cmd.ld_sel = taje_pkg::LD_U;
            taje_pkg::S_L_EQ: begin
                if (i_stat.u_eq_v) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = taje_pkg::RES_U;
                end
            end
            taje_pkg::S_L2_TOP: begin
                priority if (i_stat.par_eq) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = taje_pkg::RES_PAR_U;
                end else if (i_stat.budget_zero) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = taje_pkg::RES_NONE;
                end else begin
                    o_cmd.upd = i_stat.l2_jump ? taje_pkg::UPD_L2_J : taje_pkg::UPD_L2_P;
                end
            end
            taje_pkg::S_L2_CHK: begin
                if (i_stat.u_ok && i_stat.v_ok) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = taje_pkg::ADDR_U;
                end else begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = taje_pkg::RES_NONE;
                end
            end
            taje_pkg::S_EMIT: o_cmd.emit = i_stat.out_free;
            default: ;
        endcase
    end
endmodule
